@@ rtl/span_fill_monochrome_framebuffer_assert.svh @@
// Assertion macros shared by the span fill checker
`ifndef SPAN_FILL_MONOCHROME_FRAMEBUFFER_ASSERT_SVH
`define SPAN_FILL_MONOCHROME_FRAMEBUFFER_ASSERT_SVH

// Check a property only while out of reset
`define SFMF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property at every edge, reset included
`define SFMF_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/sfmf_pkg.sv @@
// Shared types and constants for the span fill frame buffer
`timescale 1ns / 1ps

package sfmf_pkg;

    // Result status codes
    localparam logic [1:0] ST_DRAWN  = 2'd0;
    localparam logic [1:0] ST_REJECT = 2'd1;
    localparam logic [1:0] ST_READ   = 2'd2;

    // Input function codes
    localparam logic FUNC_DRAW = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    localparam int FB_BYTES_DEF   = 1024;
    localparam logic [7:0] ROW_BYTES_RST = 8'd5;
    localparam int ADDR_MAX_W     = 16;   // enough for the largest frame store
    localparam int PROD_W         = 24;   // row times row width
    localparam int COL_W          = 11;   // clamped pixel column
    localparam logic [7:0] FULL_BYTE = 8'hFF;

    // Classified command passed from front to back
    typedef struct packed {
        logic [1:0]            kind;       // status code of the command
        logic                  in_range;   // read address inside the store
        logic                  single;     // span starts and ends in one byte
        logic [ADDR_MAX_W-1:0] start_addr;
        logic [ADDR_MAX_W-1:0] end_addr;
        logic [7:0]            first_mask;
        logic [7:0]            last_mask;
    } cmd_t;

endpackage

@@ rtl/sfmf_ram.sv @@
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps

module sfmf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and read the array
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/sfmf_front.sv @@
// Front end: accept items, order and clamp the ends, classify into commands
`timescale 1ns / 1ps

module sfmf_front
    import sfmf_pkg::*;
#(
    parameter int FB_BYTES = FB_BYTES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               func,
    input  logic signed [15:0] x_first,
    input  logic signed [15:0] x_second,
    input  logic signed [15:0] row,
    input  logic [9:0]         byte_addr,
    input  logic [7:0]         row_bytes,
    input  logic               clearing,
    output logic               push,
    output cmd_t               push_cmd,
    input  logic               q_full
);

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_CALC = 2'd1;
    localparam logic [1:0] F_PUSH = 2'd2;

    localparam logic [PROD_W-1:0] FB_LIMIT = PROD_W'(FB_BYTES);

    logic [1:0] state_reg, state_next;

    logic               func_reg;
    logic signed [15:0] xa_reg, xb_reg, row_reg;
    logic [9:0]         baddr_reg;

    logic [COL_W-1:0]  lo_c_reg, hi_c_reg, lo_c_next, hi_c_next;
    logic [PROD_W-1:0] lim_reg, base_reg, lim_next, base_next;
    logic              neg_reg, zero_reg;

    logic               accept;
    logic               first_le;
    logic signed [15:0] lo, hi;
    logic [15:0]        last_col;
    logic [14:0]        row_mag;
    logic               reject;
    logic [PROD_W-1:0]  start_full, end_full, read_full;

    assign in_stall = (state_reg != F_IDLE) || clearing;
    assign accept   = in_valid && !in_stall;
    assign first_le = (xa_reg <= xb_reg);

    // Order the ends and clamp each into the row
    always_comb
    begin
        lo       = first_le ? xa_reg : xb_reg;
        hi       = first_le ? xb_reg : xa_reg;
        last_col = {5'd0, row_bytes, 3'b000} - 16'd1;
        if (lo[15])
        begin
            lo_c_next = '0;
        end
        else if (unsigned'(lo) > last_col)
        begin
            lo_c_next = last_col[COL_W-1:0];
        end
        else
        begin
            lo_c_next = lo[COL_W-1:0];
        end
        if (hi[15])
        begin
            hi_c_next = '0;
        end
        else if (unsigned'(hi) > last_col)
        begin
            hi_c_next = last_col[COL_W-1:0];
        end
        else
        begin
            hi_c_next = hi[COL_W-1:0];
        end
        row_mag   = row_reg[14:0];
        lim_next  = (PROD_W'(row_mag) + PROD_W'(1)) * PROD_W'(row_bytes);
        base_next = PROD_W'(row_mag) * PROD_W'(row_bytes);
    end

    // Build the command from the registered products and columns
    always_comb
    begin
        reject     = neg_reg || zero_reg || (lim_reg > FB_LIMIT);
        start_full = base_reg + PROD_W'(lo_c_reg >> 3);
        end_full   = base_reg + PROD_W'(hi_c_reg >> 3);
        read_full  = PROD_W'(baddr_reg);
        push_cmd.in_range   = (read_full < FB_LIMIT);
        push_cmd.single     = (start_full == end_full);
        push_cmd.first_mask = FULL_BYTE >> lo_c_reg[2:0];
        push_cmd.last_mask  = ~(8'h7F >> hi_c_reg[2:0]);
        push_cmd.end_addr   = end_full[ADDR_MAX_W-1:0];
        if (func_reg == FUNC_READ)
        begin
            push_cmd.kind       = ST_READ;
            push_cmd.start_addr = read_full[ADDR_MAX_W-1:0];
        end
        else
        begin
            push_cmd.kind       = reject ? ST_REJECT : ST_DRAWN;
            push_cmd.start_addr = start_full[ADDR_MAX_W-1:0];
        end
        push = (state_reg == F_PUSH);
    end

    // Sequence accept, compute and hand-off
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    state_next = F_CALC;
                end
            end
            F_CALC:
            begin
                state_next = F_PUSH;
            end
            F_PUSH:
            begin
                if (!q_full)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Capture the item and the intermediate results
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg  <= func;
            xa_reg    <= x_first;
            xb_reg    <= x_second;
            row_reg   <= row;
            baddr_reg <= byte_addr;
        end
        if (state_reg == F_CALC)
        begin
            lo_c_reg <= lo_c_next;
            hi_c_reg <= hi_c_next;
            lim_reg  <= lim_next;
            base_reg <= base_next;
            neg_reg  <= row_reg[15];
            zero_reg <= (row_bytes == 8'd0);
        end
    end

endmodule

@@ rtl/sfmf_queue.sv @@
// Two-entry command queue between front and back
`timescale 1ns / 1ps

module sfmf_queue
    import sfmf_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output cmd_t pop_cmd,
    output logic empty
);

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push, do_pop;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_cmd = entry_reg[rd_ptr_reg];

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    // Store the pushed command
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

@@ rtl/sfmf_back.sv @@
// Back end: clear the frame store, then execute reads and span fills
`timescale 1ns / 1ps

module sfmf_back
    import sfmf_pkg::*;
#(
    parameter int FB_BYTES = FB_BYTES_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_empty,
    input  cmd_t       q_cmd,
    output logic       pop,
    output logic       clearing,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] status,
    output logic [7:0] read_data
);

    localparam int AW = $clog2(FB_BYTES);
    localparam logic [AW-1:0] LAST_ADDR = AW'(FB_BYTES - 1);

    localparam logic [2:0] B_CLEAR    = 3'd0;
    localparam logic [2:0] B_IDLE     = 3'd1;
    localparam logic [2:0] B_READ     = 3'd2;
    localparam logic [2:0] B_FIRST_WR = 3'd3;
    localparam logic [2:0] B_FILL     = 3'd4;
    localparam logic [2:0] B_LAST_WR  = 3'd5;

    logic [2:0]    state_reg, state_next;
    logic [AW-1:0] cur_reg, cur_next;
    cmd_t          cmd_reg, cmd_next;

    logic       res_valid_reg;
    logic [1:0] res_status_reg;
    logic [7:0] res_data_reg;
    logic       res_free, set_res;
    logic [1:0] set_status;
    logic [7:0] set_data;

    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [7:0]    ram_wdata, ram_rdata;
    logic [AW-1:0] start_a, end_a;

    sfmf_ram #(
        .WIDTH(8),
        .DEPTH(FB_BYTES)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign clearing  = (state_reg == B_CLEAR);
    assign res_free  = !res_valid_reg || !out_stall;
    assign start_a   = cmd_reg.start_addr[AW-1:0];
    assign end_a     = cmd_reg.end_addr[AW-1:0];
    assign out_valid = res_valid_reg;
    assign status    = res_status_reg;
    assign read_data = res_data_reg;

    // Step through clear, read and fill sequences
    always_comb
    begin
        state_next = state_reg;
        cur_next   = cur_reg;
        cmd_next   = cmd_reg;
        pop        = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = cur_reg;
        ram_wdata  = '0;
        ram_raddr  = q_cmd.start_addr[AW-1:0];
        set_res    = 1'b0;
        set_status = ST_DRAWN;
        set_data   = '0;
        unique case (state_reg)
            B_CLEAR:
            begin
                ram_we = 1'b1;
                if (cur_reg == LAST_ADDR)
                begin
                    cur_next   = '0;
                    state_next = B_IDLE;
                end
                else
                begin
                    cur_next = cur_reg + AW'(1);
                end
            end
            B_IDLE:
            begin
                if (!q_empty && res_free)
                begin
                    pop      = 1'b1;
                    cmd_next = q_cmd;
                    unique case (q_cmd.kind)
                        ST_READ:
                        begin
                            if (q_cmd.in_range)
                            begin
                                state_next = B_READ;
                            end
                            else
                            begin
                                set_res    = 1'b1;
                                set_status = ST_READ;
                            end
                        end
                        ST_DRAWN:
                        begin
                            state_next = B_FIRST_WR;
                        end
                        default:
                        begin
                            set_res    = 1'b1;
                            set_status = ST_REJECT;
                        end
                    endcase
                end
            end
            B_READ:
            begin
                set_res    = 1'b1;
                set_status = ST_READ;
                set_data   = ram_rdata;
                state_next = B_IDLE;
            end
            B_FIRST_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = start_a;
                if (cmd_reg.single)
                begin
                    ram_wdata  = ram_rdata | (cmd_reg.first_mask & cmd_reg.last_mask);
                    set_res    = 1'b1;
                    state_next = B_IDLE;
                end
                else
                begin
                    ram_wdata = ram_rdata | cmd_reg.first_mask;
                    cur_next  = start_a + AW'(1);
                    if (start_a + AW'(1) == end_a)
                    begin
                        ram_raddr  = end_a;
                        state_next = B_LAST_WR;
                    end
                    else
                    begin
                        state_next = B_FILL;
                    end
                end
            end
            B_FILL:
            begin
                ram_we    = 1'b1;
                ram_wdata = FULL_BYTE;
                cur_next  = cur_reg + AW'(1);
                if (cur_reg + AW'(1) == end_a)
                begin
                    ram_raddr  = end_a;
                    state_next = B_LAST_WR;
                end
            end
            B_LAST_WR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = end_a;
                ram_wdata  = ram_rdata | cmd_reg.last_mask;
                set_res    = 1'b1;
                state_next = B_IDLE;
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    // Hold control state; start with the clearing pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_CLEAR;
            cur_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cur_reg   <= cur_next;
            if (set_res)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Load the current command and the result payload
    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        if (set_res)
        begin
            res_status_reg <= set_status;
            res_data_reg   <= set_data;
        end
    end

endmodule

@@ rtl/span_fill_monochrome_framebuffer.sv @@
// Horizontal span fill into a one-bit-per-pixel frame store: top level
// Throughput: one item at a time in the front, which stalls while the queue is full;
// the back is bound by the single RAM write port, one byte per cycle once a command
// starts, and waits for a free result slot; a two-entry queue decouples them.
// Reset: asynchronous, active low; row width returns to 5 and the store is cleared
// by a pass over all FB_BYTES bytes during which no item is taken.
`timescale 1ns / 1ps

module span_fill_monochrome_framebuffer
    import sfmf_pkg::*;
#(
    parameter int FB_BYTES = FB_BYTES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [7:0]         cfg_wr_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               func,
    input  logic signed [15:0] x_first,
    input  logic signed [15:0] x_second,
    input  logic signed [15:0] row,
    input  logic [9:0]         byte_addr,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         status,
    output logic [7:0]         read_data
);

    logic [7:0] row_bytes_reg;
    logic       clearing;
    logic       push, q_full, pop, q_empty;
    cmd_t       push_cmd, q_cmd;

    // Hold the row width register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_bytes_reg <= ROW_BYTES_RST;
        end
        else if (cfg_wr_en)
        begin
            row_bytes_reg <= cfg_wr_data;
        end
    end

    sfmf_front #(
        .FB_BYTES(FB_BYTES)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .func     (func),
        .x_first  (x_first),
        .x_second (x_second),
        .row      (row),
        .byte_addr(byte_addr),
        .row_bytes(row_bytes_reg),
        .clearing (clearing),
        .push     (push),
        .push_cmd (push_cmd),
        .q_full   (q_full)
    );

    sfmf_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_cmd(push_cmd),
        .full    (q_full),
        .pop     (pop),
        .pop_cmd (q_cmd),
        .empty   (q_empty)
    );

    sfmf_back #(
        .FB_BYTES(FB_BYTES)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_cmd    (q_cmd),
        .pop      (pop),
        .clearing (clearing),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .status   (status),
        .read_data(read_data)
    );

endmodule

@@ rtl/sfmf_checker.sv @@
// Port-level checker for the span fill frame buffer, bound to the top level
`timescale 1ns / 1ps
`include "span_fill_monochrome_framebuffer_assert.svh"

module sfmf_checker
    import sfmf_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [1:0] status,
    input logic [7:0] read_data
);

    // No result is shown while reset is held
    `SFMF_ASSERT_ALWAYS(a_no_result_in_reset, !rst_n |-> !out_valid, "result valid during reset")

    // Status is always one of the defined codes
    `SFMF_ASSERT(a_status_code, out_valid |-> (status == ST_DRAWN || status == ST_REJECT || status == ST_READ), "undefined status code")

    // Draw results carry zero data
    `SFMF_ASSERT(a_draw_data_zero, (out_valid && status != ST_READ) |-> (read_data == 8'd0), "draw result with nonzero data")

    // A stalled result holds
    `SFMF_ASSERT(a_out_hold, (out_valid && out_stall) |=> (out_valid && $stable(status) && $stable(read_data)), "stalled result changed")

    // The front takes one item at a time
    `SFMF_ASSERT(a_front_busy, (in_valid && !in_stall) |=> in_stall, "front accepted back to back")

endmodule

bind span_fill_monochrome_framebuffer sfmf_checker u_sfmf_checker (.*);
